### rtl/core/mcrh_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mcrh_pkg;

	// Command codes on the cmd input.
	localparam logic [1:0] CMD_COUNT = 2'd0;
	localparam logic [1:0] CMD_CLEAR = 2'd1;
	localparam logic [1:0] CMD_READ  = 2'd2;

	// Configuration register indexes.
	localparam logic [2:0] REG_BINS_CH0   = 3'd0;
	localparam logic [2:0] REG_BINS_CH1   = 3'd1;
	localparam logic [2:0] REG_BINS_CH2   = 3'd2;
	localparam logic [2:0] REG_ROI_ENABLE = 3'd3;
	localparam logic [2:0] REG_ROI_LEFT   = 3'd4;
	localparam logic [2:0] REG_ROI_TOP    = 3'd5;
	localparam logic [2:0] REG_ROI_WIDTH  = 3'd6;
	localparam logic [2:0] REG_ROI_HEIGHT = 3'd7;

	// Bin index width covering the largest store of 1024 entries.
	localparam int BIN_IDX_W = 10;

	// Queue between the classifier and the bin engine.
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = 2;
	localparam int QCNT_W      = 3;

	// Operations handed to the bin engine.
	typedef enum logic [1:0] {
		BOP_INCR  = 2'd0,
		BOP_READ  = 2'd1,
		BOP_CLEAR = 2'd2
	} bop_t;

	typedef struct packed {
		bop_t                 op;
		logic [BIN_IDX_W-1:0] addr;
		logic                 err;
	} bitem_t;

	typedef struct packed {
		logic [7:0]  bins_ch0;
		logic [7:0]  bins_ch1;
		logic [7:0]  bins_ch2;
		logic        roi_enable;
		logic [11:0] roi_left;
		logic [11:0] roi_top;
		logic [12:0] roi_width;
		logic [12:0] roi_height;
	} cfg_t;

endpackage

`default_nettype wire

### rtl/core/mcrh_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module mcrh_queue (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    push,
	input  mcrh_pkg::bitem_t       push_item,
	input  wire                    pop,
	output mcrh_pkg::bitem_t       head_item,
	output logic                   not_empty,
	output logic [mcrh_pkg::QCNT_W-1:0] level
);
	import mcrh_pkg::*;

	bitem_t             entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QCNT_W-1:0]  count_q;

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (!push && pop)
				count_q <= count_q - 1'b1;
		end
	end

	// Entry storage, written at the tail.
	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= push_item;
	end

	assign head_item = entry_q[rd_ptr_q];
	assign not_empty = (count_q != '0);
	assign level     = count_q;

endmodule

`default_nettype wire

### rtl/core/mcrh_front.sv
`timescale 1ns / 1ps
`default_nettype none

module mcrh_front #(
	parameter int BIN_STORE_DEPTH = 768,
	parameter int COORD_WIDTH     = 12,
	parameter int NUM_CHANNELS    = 3
) (
	input  wire                         clk,
	input  wire                         arst_n,
	input  mcrh_pkg::cfg_t              cfg,
	input  wire                         start,
	output logic                        busy,
	input  wire  [1:0]                  cmd,
	input  wire  [1:0]                  channel,
	input  wire  [11:0]                 row,
	input  wire  [11:0]                 col,
	input  wire  [7:0]                  pixel_value,
	input  wire  [9:0]                  read_index,
	input  wire  [mcrh_pkg::QCNT_W-1:0] q_level,
	input  wire                         sweeping,
	output logic                        push,
	output mcrh_pkg::bitem_t            push_item
);
	import mcrh_pkg::*;

	localparam logic [11:0] COORD_MASK = (COORD_WIDTH >= 12) ? 12'hFFF :
		12'((1 << COORD_WIDTH) - 1);
	localparam logic [1:0]  NUM_CH_L   = 2'(NUM_CHANNELS);
	localparam logic [10:0] DEPTH_L    = 11'(BIN_STORE_DEPTH);

	logic        f_v_s1;
	logic [1:0]  cmd_s1;
	logic [1:0]  channel_s1;
	logic [11:0] row_s1;
	logic [11:0] col_s1;
	logic [7:0]  value_s1;
	logic [9:0]  read_index_s1;

	logic [11:0] row_m;
	logic [11:0] col_m;
	logic [7:0]  n_sel;
	logic [8:0]  base;
	logic [15:0] prod;
	logic [9:0]  idx;
	logic [9:0]  total;
	logic        ch_ok;
	logic        region_ok;
	logic        idx_ok;
	logic        read_err;
	logic [QCNT_W:0] occupancy;

	// Hold off new items when the queue could not take the one in flight, or while sweeping.
	assign occupancy = {1'b0, q_level} + {{QCNT_W{1'b0}}, f_v_s1};
	assign busy      = (occupancy >= (QCNT_W + 1)'(QUEUE_DEPTH)) || sweeping;

	// Input register: one transfer per cycle when not busy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			f_v_s1 <= 1'b0;
		end else begin
			f_v_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			cmd_s1        <= cmd;
			channel_s1    <= channel;
			row_s1        <= row;
			col_s1        <= col;
			value_s1      <= pixel_value;
			read_index_s1 <= read_index;
		end
	end

	// Channel selection and bin offset of the selected channel.
	always_comb begin
		unique case (channel_s1)
			2'd0: begin
				n_sel = cfg.bins_ch0;
				base  = 9'd0;
			end
			2'd1: begin
				n_sel = cfg.bins_ch1;
				base  = {1'b0, cfg.bins_ch0};
			end
			2'd2: begin
				n_sel = cfg.bins_ch2;
				base  = {1'b0, cfg.bins_ch0} + {1'b0, cfg.bins_ch1};
			end
			default: begin
				n_sel = 8'd0;
				base  = 9'd0;
			end
		endcase
	end

	assign ch_ok = (channel_s1 < NUM_CH_L);
	assign prod  = value_s1 * n_sel;
	assign idx   = {1'b0, base} + {2'b00, prod[15:8]};

	// Total bins over the channels that exist.
	assign total = ((NUM_CHANNELS > 0) ? {2'b00, cfg.bins_ch0} : 10'd0) +
		((NUM_CHANNELS > 1) ? {2'b00, cfg.bins_ch1} : 10'd0) +
		((NUM_CHANNELS > 2) ? {2'b00, cfg.bins_ch2} : 10'd0);

	// Region test, with the upper bounds formed without wrap.
	assign row_m = row_s1 & COORD_MASK;
	assign col_m = col_s1 & COORD_MASK;
	assign region_ok = !cfg.roi_enable || (
		(col_m >= cfg.roi_left) &&
		({2'b00, col_m} < ({2'b00, cfg.roi_left} + {1'b0, cfg.roi_width})) &&
		(row_m >= cfg.roi_top) &&
		({2'b00, row_m} < ({2'b00, cfg.roi_top} + {1'b0, cfg.roi_height})));

	assign idx_ok   = ({1'b0, idx} < DEPTH_L);
	assign read_err = !({1'b0, read_index_s1} < {1'b0, total}) ||
		!({1'b0, read_index_s1} < DEPTH_L);

	// Command decode into work for the bin engine.
	always_comb begin
		push           = 1'b0;
		push_item.op   = BOP_INCR;
		push_item.addr = idx;
		push_item.err  = 1'b0;
		unique case (cmd_s1)
			CMD_COUNT: begin
				push = f_v_s1 && ch_ok && (n_sel != 8'd0) && region_ok && idx_ok;
			end
			CMD_CLEAR: begin
				push         = f_v_s1;
				push_item.op = BOP_CLEAR;
			end
			CMD_READ: begin
				push           = f_v_s1;
				push_item.op   = BOP_READ;
				push_item.addr = read_index_s1;
				push_item.err  = read_err;
			end
			default: begin
				push = 1'b0;
			end
		endcase
	end

endmodule

`default_nettype wire

### rtl/core/mcrh_back.sv
`timescale 1ns / 1ps
`default_nettype none

module mcrh_back #(
	parameter int BIN_STORE_DEPTH = 768,
	parameter int COUNT_WIDTH     = 32
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    q_valid,
	input  mcrh_pkg::bitem_t       q_item,
	output logic                   q_pop,
	output logic                   sweeping,
	output logic                   result_valid,
	output logic [COUNT_WIDTH-1:0] bin_count,
	output logic                   index_error
);
	import mcrh_pkg::*;

	localparam int AW = $clog2(BIN_STORE_DEPTH);
	localparam logic [AW-1:0] LAST_ADDR = AW'(BIN_STORE_DEPTH - 1);
	localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

	logic [COUNT_WIDTH-1:0] mem [BIN_STORE_DEPTH];

	logic                   v_s1;
	bitem_t                 item_s1;
	logic [COUNT_WIDTH-1:0] rdata_s1;

	logic                   clear_active_q;
	logic [AW-1:0]          clr_cnt_q;

	logic                   wr_v_q;
	logic [AW-1:0]          wr_addr_q;
	logic [COUNT_WIDTH-1:0] wr_data_q;

	logic                   wr_en;
	logic [AW-1:0]          wr_addr;
	logic [COUNT_WIDTH-1:0] wr_data;
	logic [COUNT_WIDTH-1:0] cur;
	logic [AW-1:0]          addr_s1;

	logic                   result_valid_q;
	logic [COUNT_WIDTH-1:0] bin_count_q;
	logic                   index_error_q;

	// Take work from the queue unless a clear is pending or sweeping.
	assign q_pop = q_valid && !clear_active_q &&
		!(v_s1 && (item_s1.op == BOP_CLEAR));
	assign sweeping = clear_active_q;

	// Read port, registered on the transfer out of the queue.
	always_ff @(posedge clk) begin
		if (q_pop) begin
			rdata_s1 <= mem[q_item.addr[AW-1:0]];
			item_s1  <= q_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= q_pop;
		end
	end

	// The previous write has not reached the read data yet, so forward it.
	assign addr_s1 = item_s1.addr[AW-1:0];
	assign cur = (wr_v_q && (wr_addr_q == addr_s1)) ? wr_data_q : rdata_s1;

	// Single write port: the clearing sweep or a saturating increment.
	always_comb begin
		if (clear_active_q) begin
			wr_en   = 1'b1;
			wr_addr = clr_cnt_q;
			wr_data = '0;
		end else begin
			wr_en   = v_s1 && (item_s1.op == BOP_INCR);
			wr_addr = addr_s1;
			wr_data = (cur == COUNT_MAX) ? cur : cur + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
	end

	always_ff @(posedge clk) begin
		wr_addr_q <= wr_addr;
		wr_data_q <= wr_data;
	end

	// Clearing sweep: runs from reset and after each clear command.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_active_q <= 1'b1;
			clr_cnt_q      <= '0;
			wr_v_q         <= 1'b0;
		end else begin
			wr_v_q <= wr_en;
			if (clear_active_q) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
				if (clr_cnt_q == LAST_ADDR)
					clear_active_q <= 1'b0;
			end else if (v_s1 && (item_s1.op == BOP_CLEAR)) begin
				clear_active_q <= 1'b1;
				clr_cnt_q      <= '0;
			end
		end
	end

	// Result register: one strobe per read.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= v_s1 && (item_s1.op == BOP_READ);
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1 && (item_s1.op == BOP_READ)) begin
			bin_count_q   <= item_s1.err ? '0 : cur;
			index_error_q <= item_s1.err;
		end
	end

	assign result_valid = result_valid_q;
	assign bin_count    = bin_count_q;
	assign index_error  = index_error_q;

`ifndef NO_ASSERTIONS
	a_sweep_alone: assert property (@(posedge clk) disable iff (!arst_n)
		clear_active_q |-> !v_s1)
		else $error("bin engine executed an item during the clearing sweep");

	a_clear_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && (item_s1.op == BOP_CLEAR) && !clear_active_q) |=>
		(clear_active_q && (clr_cnt_q == '0)))
		else $error("clear command did not start a sweep from the first bin");

	a_no_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && !clear_active_q) |-> (wr_data != '0))
		else $error("bin count wrapped to zero instead of saturating");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid_q && index_error_q) |-> (bin_count_q == '0))
		else $error("out of range read returned a nonzero count");
`endif

endmodule

`default_nettype wire

### rtl/core/multi_channel_roi_histogram_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Histogram of up to three 8-bit colour planes with an optional region of interest.
// Input channel: an item is transferred on a rising edge with start high and busy low.
// cmd selects count pixel, clear all bins, or read one bin; other codes are dropped.
// Results come only from reads: result_valid strobes for one cycle with bin_count
// and index_error. The receiver cannot stall, so every result is taken at once.
// A read passes the input register, queue, engine read register and result register.
// Throughput: one item per cycle for counts and reads while busy is low. The bin
// store has a single write port and read-modify-write forwards the last write,
// so consecutive hits on one bin need no bubbles.
// A clear walks the store one bin per cycle, during which busy is high. After reset
// the same sweep runs, so busy stays high until the whole store has been cleared,
// and only then is the first item taken.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data, always ready; write
// only while no items are in flight. Reset restores the documented register values.
module multi_channel_roi_histogram_core #(
	parameter int BIN_STORE_DEPTH = 768,
	parameter int COUNT_WIDTH     = 32,
	parameter int COORD_WIDTH     = 12,
	parameter int NUM_CHANNELS    = 3
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    start,
	output logic                   busy,
	input  wire  [1:0]             cmd,
	input  wire  [1:0]             channel,
	input  wire  [11:0]            row,
	input  wire  [11:0]            col,
	input  wire  [7:0]             pixel_value,
	input  wire  [9:0]             read_index,
	output logic                   result_valid,
	output logic [COUNT_WIDTH-1:0] bin_count,
	output logic                   index_error,
	input  wire                    cfg_valid,
	output logic                   cfg_ready,
	input  wire  [2:0]             cfg_index,
	input  wire  [12:0]            cfg_data
);
	import mcrh_pkg::*;

	cfg_t              cfg_q;
	logic              push;
	bitem_t            push_item;
	logic              q_pop;
	bitem_t            head_item;
	logic              q_valid;
	logic [QCNT_W-1:0] q_level;
	logic              sweeping;

	assign cfg_ready = 1'b1;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.bins_ch0   <= 8'd16;
			cfg_q.bins_ch1   <= 8'd16;
			cfg_q.bins_ch2   <= 8'd16;
			cfg_q.roi_enable <= 1'b0;
			cfg_q.roi_left   <= 12'd0;
			cfg_q.roi_top    <= 12'd0;
			cfg_q.roi_width  <= 13'd4096;
			cfg_q.roi_height <= 13'd4096;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_BINS_CH0:   cfg_q.bins_ch0   <= cfg_data[7:0];
				REG_BINS_CH1:   cfg_q.bins_ch1   <= cfg_data[7:0];
				REG_BINS_CH2:   cfg_q.bins_ch2   <= cfg_data[7:0];
				REG_ROI_ENABLE: cfg_q.roi_enable <= cfg_data[0];
				REG_ROI_LEFT:   cfg_q.roi_left   <= cfg_data[11:0];
				REG_ROI_TOP:    cfg_q.roi_top    <= cfg_data[11:0];
				REG_ROI_WIDTH:  cfg_q.roi_width  <= cfg_data;
				REG_ROI_HEIGHT: cfg_q.roi_height <= cfg_data;
				default:        cfg_q.roi_enable <= cfg_q.roi_enable;
			endcase
		end
	end

	// Classifier: takes items and turns them into bin operations.
	mcrh_front #(
		.BIN_STORE_DEPTH (BIN_STORE_DEPTH),
		.COORD_WIDTH     (COORD_WIDTH),
		.NUM_CHANNELS    (NUM_CHANNELS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.start       (start),
		.busy        (busy),
		.cmd         (cmd),
		.channel     (channel),
		.row         (row),
		.col         (col),
		.pixel_value (pixel_value),
		.read_index  (read_index),
		.q_level     (q_level),
		.sweeping    (sweeping),
		.push        (push),
		.push_item   (push_item)
	);

	// Short queue between classifier and bin engine.
	mcrh_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (q_pop),
		.head_item (head_item),
		.not_empty (q_valid),
		.level     (q_level)
	);

	// Bin engine with the count store.
	mcrh_back #(
		.BIN_STORE_DEPTH (BIN_STORE_DEPTH),
		.COUNT_WIDTH     (COUNT_WIDTH)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.q_item       (head_item),
		.q_pop        (q_pop),
		.sweeping     (sweeping),
		.result_valid (result_valid),
		.bin_count    (bin_count),
		.index_error  (index_error)
	);

endmodule

`default_nettype wire

### tb/tb_multi_channel_roi_histogram_core.sv
`timescale 1ns / 1ps

module tb_multi_channel_roi_histogram_core;
	import mcrh_pkg::*;

	localparam int BIN_STORE_DEPTH = 768;
	localparam int COUNT_WIDTH     = 32;
	localparam int COORD_WIDTH     = 12;
	localparam int NUM_CHANNELS    = 3;

	localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
	// The one code of the cmd field that the block has no use for.
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	localparam int CLK_PERIOD    = 12;
	localparam int SETTLE_CYCLES = 8;
	// Reads queued behind clears wait for each clearing sweep to finish.
	localparam int RESULT_WAIT   = 4 * BIN_STORE_DEPTH;
	localparam int RANDOM_ITEMS  = 130;
	localparam int NUM_PHASES    = 11;
	localparam int NO_GAP_PHASE  = 8;
	localparam int WATCHDOG_CYCLES = 2_000_000;

	typedef struct {
		logic [1:0]  cmd;
		logic [1:0]  channel;
		logic [11:0] row;
		logic [11:0] col;
		logic [7:0]  pixel_value;
		logic [9:0]  read_index;
	} hist_item_t;

	typedef struct {
		logic [COUNT_WIDTH-1:0] bin_count;
		logic                   index_error;
	} bin_read_t;

	logic        clk         = 1'b0;
	logic        arst_n      = 1'b0;
	logic        start       = 1'b0;
	logic [1:0]  cmd         = CMD_COUNT;
	logic [1:0]  channel     = 2'd0;
	logic [11:0] row         = '0;
	logic [11:0] col         = '0;
	logic [7:0]  pixel_value = '0;
	logic [9:0]  read_index  = '0;
	logic        cfg_valid   = 1'b0;
	logic [2:0]  cfg_index   = REG_BINS_CH0;
	logic [12:0] cfg_data    = '0;

	wire                   busy;
	wire                   result_valid;
	wire [COUNT_WIDTH-1:0] bin_count;
	wire                   index_error;
	wire                   cfg_ready;

	// Our own copy of the bin store and of the register file.
	logic [COUNT_WIDTH-1:0] bin_model [BIN_STORE_DEPTH];
	cfg_t                   cfg_model;

	hist_item_t pixel_queue [$];
	bin_read_t  expected_reads [$];
	hist_item_t cur_item;
	bit         holding        = 1'b0;
	bit         no_gaps        = 1'b0;
	int         mismatch_count = 0;

	multi_channel_roi_histogram_core #(
		.BIN_STORE_DEPTH(BIN_STORE_DEPTH),
		.COUNT_WIDTH    (COUNT_WIDTH),
		.COORD_WIDTH    (COORD_WIDTH),
		.NUM_CHANNELS   (NUM_CHANNELS)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.cmd         (cmd),
		.channel     (channel),
		.row         (row),
		.col         (col),
		.pixel_value (pixel_value),
		.read_index  (read_index),
		.result_valid(result_valid),
		.bin_count   (bin_count),
		.index_error (index_error),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	initial begin
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	task automatic report_mismatch(string what);
		$display("[%0t] MISMATCH: %s", $time, what);
		mismatch_count++;
	endtask

	function automatic int unsigned channel_bins(int unsigned ch);
		case (ch)
			0: return cfg_model.bins_ch0;
			1: return cfg_model.bins_ch1;
			2: return cfg_model.bins_ch2;
			default: return 0;
		endcase
	endfunction

	// Bins of all channels below ch, which is where channel ch starts.
	function automatic int unsigned bins_below(int unsigned ch);
		int unsigned sum = 0;
		for (int unsigned k = 0; k < ch && k < 3; k++)
			sum += channel_bins(k);
		return sum;
	endfunction

	// Region test done in 32 bits so that the right and bottom edges never wrap.
	function automatic bit in_roi(int unsigned r, int unsigned c);
		int unsigned left, top, right, bottom;
		left   = cfg_model.roi_left;
		top    = cfg_model.roi_top;
		right  = left + cfg_model.roi_width;
		bottom = top + cfg_model.roi_height;
		if (!cfg_model.roi_enable)
			return 1'b1;
		return c >= left && c < right && r >= top && r < bottom;
	endfunction

	// Applies one transferred item to the store copy and queues any read result.
	task automatic update_histogram(hist_item_t it);
		int unsigned n, idx, total;
		bin_read_t   rd;
		case (it.cmd)
			CMD_COUNT: begin
				if (it.channel < NUM_CHANNELS) begin
					n   = channel_bins(it.channel);
					idx = bins_below(it.channel) + (int'(it.pixel_value) * n) / 256;
					if (n != 0 && in_roi(it.row, it.col) && idx < BIN_STORE_DEPTH &&
							bin_model[idx] != COUNT_MAX)
						bin_model[idx] = bin_model[idx] + 1'b1;
				end
			end
			CMD_CLEAR: begin
				foreach (bin_model[i])
					bin_model[i] = '0;
			end
			CMD_READ: begin
				total = bins_below(NUM_CHANNELS);
				if (it.read_index >= total || it.read_index >= BIN_STORE_DEPTH) begin
					rd.bin_count   = '0;
					rd.index_error = 1'b1;
				end else begin
					rd.bin_count   = bin_model[it.read_index];
					rd.index_error = 1'b0;
				end
				expected_reads.push_back(rd);
			end
			default: ;
		endcase
	endtask

	// One register write; the copy is updated at the edge of the transfer.
	task automatic write_reg(logic [2:0] idx, logic [12:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_BINS_CH0:   cfg_model.bins_ch0   = data[7:0];
			REG_BINS_CH1:   cfg_model.bins_ch1   = data[7:0];
			REG_BINS_CH2:   cfg_model.bins_ch2   = data[7:0];
			REG_ROI_ENABLE: cfg_model.roi_enable = data[0];
			REG_ROI_LEFT:   cfg_model.roi_left   = data[11:0];
			REG_ROI_TOP:    cfg_model.roi_top    = data[11:0];
			REG_ROI_WIDTH:  cfg_model.roi_width  = data[12:0];
			REG_ROI_HEIGHT: cfg_model.roi_height = data[12:0];
			default: ;
		endcase
	endtask

	task automatic apply_settings(cfg_t s);
		write_reg(REG_BINS_CH0, 13'(s.bins_ch0));
		write_reg(REG_BINS_CH1, 13'(s.bins_ch1));
		write_reg(REG_BINS_CH2, 13'(s.bins_ch2));
		write_reg(REG_ROI_ENABLE, 13'(s.roi_enable));
		write_reg(REG_ROI_LEFT, 13'(s.roi_left));
		write_reg(REG_ROI_TOP, 13'(s.roi_top));
		write_reg(REG_ROI_WIDTH, s.roi_width);
		write_reg(REG_ROI_HEIGHT, s.roi_height);
	endtask

	// Waits until every item is transferred and every read has returned, then lets
	// a count or clear still in the pipe finish before the block is touched again.
	task automatic drain();
		int waited = 0;
		while (pixel_queue.size() != 0 || holding)
			@(posedge clk);
		while (expected_reads.size() != 0 && waited < RESULT_WAIT) begin
			@(posedge clk);
			waited++;
		end
		while (expected_reads.size() != 0) begin
			report_mismatch("read result never arrived");
			void'(expected_reads.pop_front());
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		while (busy)
			@(posedge clk);
		// Items queued behind a clear still run once its sweep has finished.
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic hist_item_t make_item(logic [1:0] c, logic [1:0] ch, logic [11:0] r,
			logic [11:0] cl, logic [7:0] pv, logic [9:0] ri);
		hist_item_t it;
		it.cmd         = c;
		it.channel     = ch;
		it.row         = r;
		it.col         = cl;
		it.pixel_value = pv;
		it.read_index  = ri;
		return it;
	endfunction

	// Coordinates cluster on the region edges, with some anywhere in the image.
	function automatic logic [11:0] pick_coord(int unsigned first, int unsigned size);
		case ($urandom_range(0, 5))
			0: return 12'(first - 1);
			1: return 12'(first);
			2: return 12'(first + size - 1);
			3: return 12'(first + size);
			4: return 12'(first + $urandom_range(0, (size == 0) ? 0 : size - 1));
			default: return 12'($urandom_range(0, 4095));
		endcase
	endfunction

	function automatic hist_item_t random_item();
		hist_item_t  it;
		int unsigned total, sel;
		total = bins_below(NUM_CHANNELS);
		sel   = $urandom_range(0, 99);
		if (sel < 68)
			it.cmd = CMD_COUNT;
		else if (sel < 96)
			it.cmd = CMD_READ;
		else if (sel < 98)
			it.cmd = CMD_CLEAR;
		else
			it.cmd = CMD_UNUSED;
		it.channel = ($urandom_range(0, 19) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
		it.row     = pick_coord(cfg_model.roi_top, cfg_model.roi_height);
		it.col     = pick_coord(cfg_model.roi_left, cfg_model.roi_width);
		case ($urandom_range(0, 7))
			0: it.pixel_value = 8'd0;
			1: it.pixel_value = 8'd255;
			default: it.pixel_value = 8'($urandom_range(0, 255));
		endcase
		sel = $urandom_range(0, 9);
		if (total != 0 && sel < 6)
			it.read_index = 10'($urandom_range(0, total - 1));
		else if (sel < 8)
			it.read_index = 10'(total - 1 + sel % 2);
		else
			it.read_index = 10'($urandom_range(0, 1023));
		return it;
	endfunction

	// Register settings of one phase: fixed extremes first, then random ones.
	function automatic cfg_t phase_settings(int p);
		cfg_t s;
		s.bins_ch0   = 8'($urandom_range(0, 255));
		s.bins_ch1   = 8'($urandom_range(0, 255));
		s.bins_ch2   = 8'($urandom_range(0, 255));
		s.roi_enable = 1'($urandom_range(0, 1));
		s.roi_left   = 12'($urandom_range(0, 4095));
		s.roi_top    = 12'($urandom_range(0, 4095));
		s.roi_width  = 13'($urandom_range(0, 4096));
		s.roi_height = 13'($urandom_range(0, 4096));
		case (p)
			0: begin
				s.bins_ch0   = 8'd255;
				s.bins_ch1   = 8'd255;
				s.bins_ch2   = 8'd255;
				s.roi_enable = 1'b0;
			end
			1: begin
				s.bins_ch0   = 8'd1;
				s.bins_ch1   = 8'd1;
				s.bins_ch2   = 8'd1;
				s.roi_enable = 1'b1;
				s.roi_left   = 12'd0;
				s.roi_top    = 12'd0;
				s.roi_width  = 13'd4096;
				s.roi_height = 13'd4096;
			end
			2: begin
				s.bins_ch0 = 8'd0;
				s.bins_ch1 = 8'd0;
				s.bins_ch2 = 8'd0;
			end
			3: begin
				s.bins_ch0   = 8'd0;
				s.bins_ch1   = 8'd255;
				s.bins_ch2   = 8'd7;
				s.roi_enable = 1'b1;
				s.roi_left   = 12'd100;
				s.roi_top    = 12'd200;
				s.roi_width  = 13'd10;
				s.roi_height = 13'd5;
			end
			4: begin
				s.roi_enable = 1'b1;
				s.roi_left   = 12'd4095;
				s.roi_top    = 12'd4095;
				s.roi_width  = 13'd4096;
				s.roi_height = 13'd4096;
			end
			5: begin
				s.roi_enable = 1'b1;
				s.roi_width  = 13'd0;
			end
			6: begin
				s.roi_enable = 1'b1;
				s.roi_height = 13'd0;
			end
			7: begin
				s.roi_enable = 1'b1;
				s.roi_width  = 13'd1;
				s.roi_height = 13'd1;
			end
			default: ;
		endcase
		return s;
	endfunction

	// Driver: presents queued items and holds each one until its transfer.
	always @(posedge clk) begin : pixel_driver
		if (arst_n) begin
			if (start && !busy) begin
				update_histogram(cur_item);
				holding = 1'b0;
			end
			if (!start || !busy) begin
				if (pixel_queue.size() != 0 && (no_gaps || $urandom_range(0, 99) >= 10)) begin
					cur_item    = pixel_queue.pop_front();
					holding     = 1'b1;
					start       <= 1'b1;
					cmd         <= cur_item.cmd;
					channel     <= cur_item.channel;
					row         <= cur_item.row;
					col         <= cur_item.col;
					pixel_value <= cur_item.pixel_value;
					read_index  <= cur_item.read_index;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// Monitor: each read result is checked against the oldest expectation.
	always @(posedge clk) begin : result_monitor
		bin_read_t exp_rd;
		if (arst_n && result_valid) begin
			if (expected_reads.size() == 0) begin
				report_mismatch($sformatf("unexpected read result, count %0d error %0b",
					bin_count, index_error));
			end else begin
				exp_rd = expected_reads.pop_front();
				if (bin_count !== exp_rd.bin_count)
					report_mismatch($sformatf("bin_count %0d, expected %0d",
						bin_count, exp_rd.bin_count));
				if (index_error !== exp_rd.index_error)
					report_mismatch($sformatf("index_error %0b, expected %0b",
						index_error, exp_rd.index_error));
			end
		end
	end

	// Stimulus: directed items on the reset settings, then random phases.
	initial begin
		foreach (bin_model[i])
			bin_model[i] = '0;
		cfg_model.bins_ch0   = 8'd16;
		cfg_model.bins_ch1   = 8'd16;
		cfg_model.bins_ch2   = 8'd16;
		cfg_model.roi_enable = 1'b0;
		cfg_model.roi_left   = 12'd0;
		cfg_model.roi_top    = 12'd0;
		cfg_model.roi_width  = 13'd4096;
		cfg_model.roi_height = 13'd4096;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Lowest and highest value on channel 0, a repeated hit on one channel 2 bin,
		// an ignored channel and command, reads at and past the end, and a clear.
		pixel_queue.push_back(make_item(CMD_COUNT, 2'd0, 12'd0, 12'd0, 8'd0, 10'd0));
		pixel_queue.push_back(make_item(CMD_COUNT, 2'd0, 12'd4095, 12'd4095, 8'd255, 10'd1023));
		pixel_queue.push_back(make_item(CMD_COUNT, 2'd1, 12'd5, 12'd7, 8'd128, 10'd0));
		pixel_queue.push_back(make_item(CMD_COUNT, 2'd2, 12'd0, 12'd0, 8'd255, 10'd0));
		pixel_queue.push_back(make_item(CMD_COUNT, 2'd2, 12'd0, 12'd0, 8'd255, 10'd0));
		pixel_queue.push_back(make_item(CMD_COUNT, 2'd3, 12'd0, 12'd0, 8'd0, 10'd0));
		pixel_queue.push_back(make_item(CMD_UNUSED, 2'd0, 12'd0, 12'd0, 8'd0, 10'd0));
		pixel_queue.push_back(make_item(CMD_COUNT, 2'd0, 12'd0, 12'd0, 8'd17, 10'd0));
		pixel_queue.push_back(make_item(CMD_READ, 2'd0, 12'd0, 12'd0, 8'd0, 10'd1));
		pixel_queue.push_back(make_item(CMD_READ, 2'd0, 12'd0, 12'd0, 8'd0, 10'd0));
		pixel_queue.push_back(make_item(CMD_READ, 2'd0, 12'd0, 12'd0, 8'd0, 10'd15));
		pixel_queue.push_back(make_item(CMD_READ, 2'd0, 12'd0, 12'd0, 8'd0, 10'd24));
		pixel_queue.push_back(make_item(CMD_READ, 2'd0, 12'd0, 12'd0, 8'd0, 10'd47));
		pixel_queue.push_back(make_item(CMD_READ, 2'd0, 12'd0, 12'd0, 8'd0, 10'd48));
		pixel_queue.push_back(make_item(CMD_READ, 2'd3, 12'd4095, 12'd4095, 8'd255, 10'd1023));
		pixel_queue.push_back(make_item(CMD_CLEAR, 2'd0, 12'd0, 12'd0, 8'd0, 10'd0));
		pixel_queue.push_back(make_item(CMD_READ, 2'd0, 12'd0, 12'd0, 8'd0, 10'd47));
		pixel_queue.push_back(make_item(CMD_COUNT, 2'd1, 12'd0, 12'd0, 8'd255, 10'd0));
		pixel_queue.push_back(make_item(CMD_READ, 2'd0, 12'd0, 12'd0, 8'd0, 10'd31));
		pixel_queue.push_back(make_item(CMD_READ, 2'd0, 12'd0, 12'd0, 8'd0, 10'd0));
		drain();

		for (int p = 0; p < NUM_PHASES; p++) begin
			apply_settings(phase_settings(p));
			no_gaps = (p == NO_GAP_PHASE);
			repeat (RANDOM_ITEMS)
				pixel_queue.push_back(random_item());
			drain();
		end

		if (mismatch_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	// Watchdog against a hung handshake.
	initial begin
		#(CLK_PERIOD * WATCHDOG_CYCLES);
		$display("Some tests failed");
		$finish;
	end

endmodule

### files.f
rtl/core/mcrh_pkg.sv
rtl/core/mcrh_queue.sv
rtl/core/mcrh_front.sv
rtl/core/mcrh_back.sv
rtl/core/multi_channel_roi_histogram_core.sv
tb/tb_multi_channel_roi_histogram_core.sv
